>>> hdl/lspr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lspr_pkg;

   localparam int EVENT_SLOTS = 8;
   localparam int SLOT_W      = (EVENT_SLOTS > 1) ? $clog2(EVENT_SLOTS) : 1;
   localparam int TIME_W      = 32;
   localparam int CODE_W      = 4;
   localparam int FLAG_W      = 8;

   localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(EVENT_SLOTS - 1);

   typedef enum logic [1:0] {
      FUNC_FLAGS = 2'd0,
      FUNC_PUSH  = 2'd1,
      FUNC_QUERY = 2'd2,
      FUNC_SPARE = 2'd3
   } func_type;

   typedef struct packed {
      logic [CODE_W-1:0] code;
      logic [TIME_W-1:0] expiry;
   } slot_type;

   typedef struct packed {
      logic live;
      logic take;
   } cmp_res_type;

endpackage

`default_nettype wire

>>> hdl/lspr_cmp.sv
`timescale 1ns / 1ps
`default_nettype none

module lspr_cmp (
   input  wire logic [lspr_pkg::TIME_W-1:0] expiry,
   input  wire logic [lspr_pkg::TIME_W-1:0] now,
   input  wire logic [lspr_pkg::TIME_W-1:0] best,
   input  wire logic                        have,
   output lspr_pkg::cmp_res_type            res
);

   logic [lspr_pkg::TIME_W-1:0] d_now;
   logic [lspr_pkg::TIME_W-1:0] d_best;
   logic                        after_now;
   logic                        after_best;

   // wraparound-safe ordering: b after a when b - a is positive as signed
   assign d_now      = expiry - now;
   assign d_best     = expiry - best;
   assign after_now  = (d_now != '0) && !d_now[lspr_pkg::TIME_W-1];
   assign after_best = (d_best != '0) && !d_best[lspr_pkg::TIME_W-1];

   assign res.live = (expiry != '0) && after_now;
   assign res.take = res.live && (!have || after_best);

endmodule

`default_nettype wire

>>> hdl/led_status_priority_resolver.sv
`timescale 1ns / 1ps
`default_nettype none

// Resolves the status LED code from eight condition flags and a ring of timed
// events. Every request first applies its flag update or event push, then
// returns one response. When any flag is set the response comes from the flags
// (the lowest set flag wins) and goes from the start state straight to the done
// state. Otherwise the single compare unit walks the event slots one per cycle
// through the slot memory read port in the scan state, then passes through the
// drain and done states. A request is taken only in the idle state, after the
// previous response has been loaded into the output register. A finished
// response sits in an output register and does not hold off the next request;
// only the following response waits while it is stalled.

module led_status_priority_resolver (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output      logic                          req_stall,
   input  wire logic [1:0]                    req_func,
   input  wire logic [lspr_pkg::FLAG_W-1:0]   req_flag_mask,
   input  wire logic                          req_flag_value,
   input  wire logic [lspr_pkg::CODE_W-1:0]   req_event_code,
   input  wire logic [lspr_pkg::TIME_W-1:0]   req_duration_ms,
   input  wire logic [lspr_pkg::TIME_W-1:0]   req_now_ms,
   output      logic                          rsp_valid,
   input  wire logic                          rsp_stall,
   output      logic [lspr_pkg::CODE_W-1:0]   rsp_led_code,
   output      logic                          rsp_from_event
);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_START = 5'b00010,
      ST_SCAN  = 5'b00100,
      ST_DRAIN = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

   state_type                     state_ff, state_in;
   logic [lspr_pkg::FLAG_W-1:0]   flags_ff, flags_in;
   logic [lspr_pkg::SLOT_W-1:0]   wp_ff, wp_in;
   logic [lspr_pkg::SLOT_W-1:0]   rd_idx_ff, rd_idx_in;
   logic                          cmp_en_ff, cmp_en_in;
   logic                          have_ff, have_in;
   logic [lspr_pkg::TIME_W-1:0]   best_ff, best_in;
   logic [lspr_pkg::CODE_W-1:0]   best_code_ff, best_code_in;
   logic [lspr_pkg::TIME_W-1:0]   now_ff, now_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [lspr_pkg::CODE_W-1:0]   rsp_code_ff, rsp_code_in;
   logic                          rsp_ev_ff, rsp_ev_in;
   logic [lspr_pkg::EVENT_SLOTS-1:0] slot_vld_ff, slot_vld_in;

   lspr_pkg::slot_type            slot_mem [lspr_pkg::EVENT_SLOTS];
   lspr_pkg::slot_type            rd_entry_ff;
   logic                          rd_vld_ff;

   logic                          accept;
   logic                          mem_we;
   lspr_pkg::slot_type            wr_entry;
   logic [lspr_pkg::TIME_W-1:0]   cand_expiry;
   lspr_pkg::cmp_res_type         cmp_res;
   logic                          load_out;
   logic [lspr_pkg::CODE_W-1:0]   flag_code;

   function automatic logic [lspr_pkg::CODE_W-1:0] prio_code(
      input logic [lspr_pkg::FLAG_W-1:0] f
   );
      logic [lspr_pkg::CODE_W-1:0] c;
      c = '0;
      for (int i = lspr_pkg::FLAG_W - 1; i >= 0; i--) begin
         if (f[i]) begin
            c = lspr_pkg::CODE_W'(i + 1);
         end
      end
      return c;
   endfunction

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign mem_we    = accept && (req_func == lspr_pkg::FUNC_PUSH) && (req_duration_ms != '0);
   assign wr_entry.code   = req_event_code;
   assign wr_entry.expiry = req_now_ms + req_duration_ms;

   // slot that was never written reads as empty
   assign cand_expiry = rd_vld_ff ? rd_entry_ff.expiry : '0;
   assign flag_code   = prio_code(flags_ff);

   lspr_cmp u_cmp (
      .expiry (cand_expiry),
      .now    (now_ff),
      .best   (best_ff),
      .have   (have_ff),
      .res    (cmp_res)
   );

   always_comb begin
      state_in     = state_ff;
      flags_in     = flags_ff;
      wp_in        = wp_ff;
      rd_idx_in    = rd_idx_ff;
      cmp_en_in    = 1'b0;
      have_in      = have_ff;
      best_in      = best_ff;
      best_code_in = best_code_ff;
      now_in       = now_ff;
      slot_vld_in  = slot_vld_ff;
      load_out     = 1'b0;
      rsp_code_in  = rsp_code_ff;
      rsp_ev_in    = rsp_ev_ff;

      if (cmp_en_ff && cmp_res.take) begin
         have_in      = 1'b1;
         best_in      = cand_expiry;
         best_code_in = rd_entry_ff.code;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               now_in = req_now_ms;
               if (req_func == lspr_pkg::FUNC_FLAGS) begin
                  if (req_flag_value) begin
                     flags_in = flags_ff | req_flag_mask;
                  end else begin
                     flags_in = flags_ff & ~req_flag_mask;
                  end
               end
               if (mem_we) begin
                  slot_vld_in[wp_ff] = 1'b1;
                  wp_in = (wp_ff == lspr_pkg::SLOT_LAST) ? '0 : wp_ff + 1'b1;
               end
               state_in = ST_START;
            end
         end
         ST_START: begin
            have_in   = 1'b0;
            rd_idx_in = '0;
            state_in  = (flags_ff != '0) ? ST_DONE : ST_SCAN;
         end
         ST_SCAN: begin
            cmp_en_in = 1'b1;
            if (rd_idx_ff == lspr_pkg::SLOT_LAST) begin
               state_in = ST_DRAIN;
            end else begin
               rd_idx_in = rd_idx_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               load_out = 1'b1;
               state_in = ST_IDLE;
               if (flags_ff != '0) begin
                  rsp_code_in = flag_code;
                  rsp_ev_in   = 1'b0;
               end else if (have_ff) begin
                  rsp_code_in = best_code_ff;
                  rsp_ev_in   = 1'b1;
               end else begin
                  rsp_code_in = '0;
                  rsp_ev_in   = 1'b0;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = load_out || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         flags_ff     <= '0;
         wp_ff        <= '0;
         rd_idx_ff    <= '0;
         cmp_en_ff    <= 1'b0;
         have_ff      <= 1'b0;
         slot_vld_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         flags_ff     <= flags_in;
         wp_ff        <= wp_in;
         rd_idx_ff    <= rd_idx_in;
         cmp_en_ff    <= cmp_en_in;
         have_ff      <= have_in;
         slot_vld_ff  <= slot_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      best_ff      <= best_in;
      best_code_ff <= best_code_in;
      now_ff       <= now_in;
      rsp_code_ff  <= rsp_code_in;
      rsp_ev_ff    <= rsp_ev_in;
   end

   // slot memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[wp_ff] <= wr_entry;
      end
      rd_entry_ff <= slot_mem[rd_idx_ff];
      rd_vld_ff   <= slot_vld_ff[rd_idx_ff];
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_led_code   = rsp_code_ff;
   assign rsp_from_event = rsp_ev_ff;

endmodule

`default_nettype wire

>>> hdl/lspr_chk.sv
`timescale 1ns / 1ps
`default_nettype none

module lspr_chk (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        req_valid,
   input wire logic                        req_stall,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_stall,
   input wire logic [lspr_pkg::CODE_W-1:0] rsp_led_code,
   input wire logic                        rsp_from_event
);

   // one request at a time: the block reports busy after a request is taken
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while previous request in flight");

   a_busy_two: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |-> ##2 req_stall)
      else $error("request finished too early");

   // a new response only appears at the end of a request
   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("response without a request in progress");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_led_code)
         && $stable(rsp_from_event))
      else $error("stalled response changed");

endmodule

bind led_status_priority_resolver lspr_chk u_lspr_chk (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_led_code   (rsp_led_code),
   .rsp_from_event (rsp_from_event)
);

`default_nettype wire
